FILE: design/dtrr_pkg.sv
// ----------------------------------------------------------------------------
// dtrr_pkg
// Shared types, widths and constants of the dual tilt relative rotation unit.
// ----------------------------------------------------------------------------
package dtrr_pkg;

    localparam int ANGLE_FRAC_BITS = 16;
    localparam int ACC_FRAC        = 24;
    localparam int CORDIC_STEPS    = 28;
    localparam int PRESCALE        = 30;

    localparam int RAW_W  = 16;
    localparam int DIFF_W = RAW_W + 1;
    localparam int PROD_W = DIFF_W + 8;
    localparam int NUM_W  = 24;
    localparam int DEN_W  = RAW_W + 1;
    localparam int REM_W  = DEN_W + 1;
    localparam int AXIS_W = 25;
    localparam int VEC_W  = 58;
    localparam int ACC_W  = 34;
    localparam int DEG_W  = 9;
    localparam int ROT_W  = 10;
    localparam int TQ_W   = DEG_W + ANGLE_FRAC_BITS;
    localparam int IDX_W  = 2;

    localparam int CFG_MIN_RAW = 0;
    localparam int CFG_MAX_RAW = 1;

    localparam logic signed [RAW_W-1:0] MIN_RAW_RST = 16'sd265;
    localparam logic signed [RAW_W-1:0] MAX_RAW_RST = 16'sd402;

    typedef logic signed [RAW_W-1:0]  t_raw;
    typedef logic signed [AXIS_W-1:0] t_axis;
    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic [DEG_W-1:0]         t_deg;
    typedef logic signed [DEG_W-1:0]  t_off;
    typedef logic signed [ROT_W-1:0]  t_rot;

    typedef struct packed {
        logic [DEN_W-1:0] mag;
        logic             neg;
        logic             zero;
    } t_den;

    localparam t_acc ACC_DEG90  = t_acc'(64'sd90 <<< ACC_FRAC);
    localparam t_acc ACC_DEG180 = t_acc'(64'sd180 <<< ACC_FRAC);

    // round(atan(2^-i) in degrees * 2^24)
    function automatic t_acc atan_entry(input int i);
        unique case (i)
            0:  atan_entry = t_acc'(754974720);
            1:  atan_entry = t_acc'(445687602);
            2:  atan_entry = t_acc'(235489088);
            3:  atan_entry = t_acc'(119537938);
            4:  atan_entry = t_acc'(60000934);
            5:  atan_entry = t_acc'(30029717);
            6:  atan_entry = t_acc'(15018523);
            7:  atan_entry = t_acc'(7509720);
            8:  atan_entry = t_acc'(3754917);
            9:  atan_entry = t_acc'(1877466);
            10: atan_entry = t_acc'(938734);
            11: atan_entry = t_acc'(469367);
            12: atan_entry = t_acc'(234684);
            13: atan_entry = t_acc'(117342);
            14: atan_entry = t_acc'(58671);
            15: atan_entry = t_acc'(29335);
            16: atan_entry = t_acc'(14668);
            17: atan_entry = t_acc'(7334);
            18: atan_entry = t_acc'(3667);
            19: atan_entry = t_acc'(1833);
            20: atan_entry = t_acc'(917);
            21: atan_entry = t_acc'(458);
            22: atan_entry = t_acc'(229);
            23: atan_entry = t_acc'(115);
            24: atan_entry = t_acc'(57);
            25: atan_entry = t_acc'(29);
            26: atan_entry = t_acc'(14);
            27: atan_entry = t_acc'(7);
            default: atan_entry = '0;
        endcase
    endfunction

endpackage

FILE: design/dtrr_map.sv
// ----------------------------------------------------------------------------
// dtrr_map
// Maps two raw axes, min to -90, max to 90, via a one-bit-per-stage divider.
// ----------------------------------------------------------------------------
module dtrr_map (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_valid,
    input  dtrr_pkg::t_raw i_raw_a,
    input  dtrr_pkg::t_raw i_raw_b,
    input  dtrr_pkg::t_raw i_min,
    input  dtrr_pkg::t_den i_den,
    output logic           o_valid,
    output dtrr_pkg::t_axis o_axis_a,
    output dtrr_pkg::t_axis o_axis_b
);
    import dtrr_pkg::*;

    localparam int NSTG = NUM_W + 3;

    logic [NSTG-1:0] r_vld;
    t_raw            w_raw [2];
    t_axis           w_axis [2];

    assign w_raw[0] = i_raw_a;
    assign w_raw[1] = i_raw_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    genvar l, k;
    generate
        for (l = 0; l < 2; l++) begin : g_lane
            logic signed [DIFF_W-1:0] r_diff;
            logic signed [PROD_W-1:0] w_prod;
            logic [PROD_W-1:0]        w_abs;
            logic [REM_W-1:0]         r_rem [0:NUM_W];
            logic [NUM_W-1:0]         r_num [0:NUM_W];
            logic [NUM_W-1:0]         r_quo [0:NUM_W];
            logic                     r_sgn [0:NUM_W];
            logic signed [AXIS_W-1:0] w_q;
            t_axis                    r_axis;

            assign w_prod = {{(PROD_W-DIFF_W){r_diff[DIFF_W-1]}}, r_diff} * PROD_W'(180);
            assign w_abs  = w_prod[PROD_W-1] ? PROD_W'(-w_prod) : PROD_W'(w_prod);

            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_diff   <= {w_raw[l][RAW_W-1], w_raw[l]} - {i_min[RAW_W-1], i_min};
                    r_rem[0] <= '0;
                    r_num[0] <= w_abs[NUM_W-1:0];
                    r_quo[0] <= '0;
                    r_sgn[0] <= w_prod[PROD_W-1] ^ i_den.neg;
                end
            end

            for (k = 1; k <= NUM_W; k++) begin : g_div
                logic [REM_W-1:0] w_sh;
                logic             w_ge;

                assign w_sh = {r_rem[k-1][REM_W-2:0], r_num[k-1][NUM_W-1]};
                assign w_ge = (w_sh >= {1'b0, i_den.mag});

                always_ff @(posedge i_clk) begin
                    if (i_adv) begin
                        r_rem[k] <= w_ge ? (w_sh - {1'b0, i_den.mag}) : w_sh;
                        r_num[k] <= {r_num[k-1][NUM_W-2:0], 1'b0};
                        r_quo[k] <= {r_quo[k-1][NUM_W-2:0], w_ge};
                        r_sgn[k] <= r_sgn[k-1];
                    end
                end
            end

            assign w_q = r_sgn[NUM_W] ? -$signed({1'b0, r_quo[NUM_W]})
                                      :  $signed({1'b0, r_quo[NUM_W]});

            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_axis <= i_den.zero ? t_axis'(-90) : t_axis'(w_q - 25'sd90);
                end
            end

            assign w_axis[l] = r_axis;
        end
    endgenerate

    assign o_valid  = r_vld[NSTG-1];
    assign o_axis_a = w_axis[0];
    assign o_axis_b = w_axis[1];

endmodule

FILE: design/dtrr_cordic.sv
// ----------------------------------------------------------------------------
// dtrr_cordic
// Pipelined CORDIC vectoring: atan2(-a, -b) in Q.24 degrees, one stage per step.
// ----------------------------------------------------------------------------
module dtrr_cordic (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic            i_valid,
    input  dtrr_pkg::t_axis i_a,
    input  dtrr_pkg::t_axis i_b,
    output logic            o_valid,
    output dtrr_pkg::t_acc  o_acc
);
    import dtrr_pkg::*;

    localparam int NSTG = CORDIC_STEPS + 1;

    logic [NSTG-1:0]          r_vld;
    logic signed [VEC_W-1:0]  r_px [0:CORDIC_STEPS];
    logic signed [VEC_W-1:0]  r_py [0:CORDIC_STEPS];
    t_acc                     r_acc [0:CORDIC_STEPS];

    logic signed [AXIS_W:0]   w_x, w_y;
    logic signed [VEC_W-1:0]  w_sx, w_sy, n_px, n_py;
    t_acc                     n_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    assign w_y  = -{i_a[AXIS_W-1], i_a};
    assign w_x  = -{i_b[AXIS_W-1], i_b};
    assign w_sx = $signed({{(VEC_W-AXIS_W-1){w_x[AXIS_W]}}, w_x}) <<< PRESCALE;
    assign w_sy = $signed({{(VEC_W-AXIS_W-1){w_y[AXIS_W]}}, w_y}) <<< PRESCALE;

    // axis-aligned vectors resolve at once; left half-plane is rotated by 90
    always_comb begin
        n_px  = w_sx;
        n_py  = w_sy;
        n_acc = '0;
        priority if (w_y == '0) begin
            n_px  = '0;
            n_py  = '0;
            n_acc = (w_x < 0) ? ACC_DEG180 : '0;
        end else if (w_x == '0) begin
            n_px  = '0;
            n_py  = '0;
            n_acc = (w_y > 0) ? ACC_DEG90 : -ACC_DEG90;
        end else if (w_sx < 0) begin
            if (w_sy >= 0) begin
                n_px  = w_sy;
                n_py  = -w_sx;
                n_acc = ACC_DEG90;
            end else begin
                n_px  = -w_sy;
                n_py  = w_sx;
                n_acc = -ACC_DEG90;
            end
        end else begin
            // right half-plane enters unrotated
            n_acc = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_px[0]  <= n_px;
            r_py[0]  <= n_py;
            r_acc[0] <= n_acc;
        end
    end

    genvar i;
    generate
        for (i = 0; i < CORDIC_STEPS; i++) begin : g_step
            logic signed [VEC_W-1:0] w_dx, w_dy;

            assign w_dx = r_py[i] >>> i;
            assign w_dy = r_px[i] >>> i;

            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    // hold once the vector lies on the axis
                    if (r_py[i] == '0) begin
                        r_px[i+1]  <= r_px[i];
                        r_py[i+1]  <= r_py[i];
                        r_acc[i+1] <= r_acc[i];
                    end else if (r_py[i] > 0) begin
                        r_px[i+1]  <= r_px[i] + w_dx;
                        r_py[i+1]  <= r_py[i] - w_dy;
                        r_acc[i+1] <= r_acc[i] + atan_entry(i);
                    end else begin
                        r_px[i+1]  <= r_px[i] - w_dx;
                        r_py[i+1]  <= r_py[i] + w_dy;
                        r_acc[i+1] <= r_acc[i] - atan_entry(i);
                    end
                end
            end
        end
    endgenerate

    assign o_valid = r_vld[NSTG-1];
    assign o_acc   = r_acc[CORDIC_STEPS];

endmodule

FILE: design/dtrr_post.sv
// ----------------------------------------------------------------------------
// dtrr_post
// Turns both angles into whole degrees, signed offsets and the stick rotation.
// ----------------------------------------------------------------------------
module dtrr_post (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_valid,
    input  dtrr_pkg::t_acc i_acc_one,
    input  dtrr_pkg::t_acc i_acc_two,
    output logic           o_valid,
    output dtrr_pkg::t_deg o_tilt_one,
    output dtrr_pkg::t_off o_offset_one,
    output dtrr_pkg::t_deg o_tilt_two,
    output dtrr_pkg::t_off o_offset_two,
    output dtrr_pkg::t_rot o_stick_rotation
);
    import dtrr_pkg::*;

    localparam logic signed [ACC_W:0] HALF_TURN = (ACC_W+1)'(64'sd180 <<< ACC_FRAC);
    localparam logic signed [ACC_W:0] FULL_TURN = (ACC_W+1)'(64'sd360 <<< ACC_FRAC);
    localparam logic [TQ_W-1:0]       FULL_TQ   = TQ_W'(360) << ANGLE_FRAC_BITS;

    // shift by 180, clamp to [0, 360] and floor to the output fraction
    function automatic logic [TQ_W-1:0] to_tq(input t_acc acc);
        logic signed [ACC_W:0] t;
        t = {acc[ACC_W-1], acc} + HALF_TURN;
        if (t < 0) begin
            t = '0;
        end else if (t > FULL_TURN) begin
            t = FULL_TURN;
        end
        return t[ACC_FRAC+DEG_W-1 -: TQ_W];
    endfunction

    logic [2:0]      r_vld;
    logic [TQ_W-1:0] r_tq1, r_tq2, w_rest;
    t_deg            r_g1, r_g2, r_og1, r_og2, w_g1, w_g2;
    t_off            r_off1, r_off2, r_oo1, r_oo2, w_off2;
    t_rot            r_rot, w_a, w_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    assign w_g1   = r_tq1[TQ_W-1 -: DEG_W];
    assign w_g2   = r_tq2[TQ_W-1 -: DEG_W];
    assign w_rest = FULL_TQ - r_tq2;
    assign w_off2 = (w_g2 <= t_deg'(180)) ? t_off'(w_g2)
                                          : -t_off'(w_rest[TQ_W-1 -: DEG_W]);

    assign w_a = r_off1[DEG_W-1] ? -t_rot'(r_off1) : t_rot'(r_off1);
    assign w_b = r_off2[DEG_W-1] ? -t_rot'(r_off2) : t_rot'(r_off2);

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_tq1  <= to_tq(i_acc_one);
            r_tq2  <= to_tq(i_acc_two);
            r_g1   <= w_g1;
            r_g2   <= w_g2;
            r_off1 <= (w_g1 <= t_deg'(180)) ? t_off'(w_g1) : t_off'(w_g1 - t_deg'(360));
            r_off2 <= w_off2;
            r_og1  <= r_g1;
            r_og2  <= r_g2;
            r_oo1  <= r_off1;
            r_oo2  <= r_off2;
            r_rot  <= (r_off1 > 0 && r_off2 <= 0) ? (w_b + w_a) : (w_b - w_a);
        end
    end

    assign o_valid          = r_vld[2];
    assign o_tilt_one       = r_og1;
    assign o_offset_one     = r_oo1;
    assign o_tilt_two       = r_og2;
    assign o_offset_two     = r_oo2;
    assign o_stick_rotation = r_rot;

endmodule

FILE: design/dual_tilt_relative_rotation_unit.sv
// ----------------------------------------------------------------------------
// dual_tilt_relative_rotation_unit
// Tilt angles of two accelerometers and the relative stick rotation.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_ready) takes one raw sample pair per transaction:
// x and z of the first sensor, y and z of the second. Output channel
// (o_valid / i_ready) returns one transaction per sample: both tilts in whole
// degrees, both wrapped offsets and the stick rotation.
// The config port writes min_raw (index 0) and max_raw (index 1) on
// i_cfg_we; other indexes are ignored. Write only while the pipeline is empty.
// Each sample passes through the axis mapping (with its bit-per-stage
// divider), the CORDIC stages and the angle post-processing. One
// transaction enters per cycle when the receiver takes
// results. The whole pipeline moves on one advance signal: when a result
// waits in the output register and i_ready is low, every stage holds and
// o_ready drops; nothing is lost or repeated. Reset clears all valid bits
// and loads the calibration 265 / 402.
// ----------------------------------------------------------------------------
module dual_tilt_relative_rotation_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  dtrr_pkg::t_raw              i_accel1_x,
    input  dtrr_pkg::t_raw              i_accel1_z,
    input  dtrr_pkg::t_raw              i_accel2_y,
    input  dtrr_pkg::t_raw              i_accel2_z,
    output logic                        o_valid,
    input  logic                        i_ready,
    output dtrr_pkg::t_deg              o_tilt_one,
    output dtrr_pkg::t_off              o_offset_one,
    output dtrr_pkg::t_deg              o_tilt_two,
    output dtrr_pkg::t_off              o_offset_two,
    output dtrr_pkg::t_rot              o_stick_rotation,
    input  logic                        i_cfg_we,
    input  logic [dtrr_pkg::IDX_W-1:0]  i_cfg_idx,
    input  logic [dtrr_pkg::RAW_W-1:0]  i_cfg_data
);
    import dtrr_pkg::*;

    t_raw                     r_min_raw, r_max_raw;
    t_den                     r_den;
    logic signed [DEN_W-1:0]  w_den;
    logic                     w_adv;
    logic                     w_vm1, w_vm2, w_vc1, w_vc2;
    t_axis                    w_m1x, w_m1z, w_m2y, w_m2z;
    t_acc                     w_acc1, w_acc2;

    assign w_adv   = !o_valid || i_ready;
    assign o_ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_raw <= MIN_RAW_RST;
            r_max_raw <= MAX_RAW_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == IDX_W'(CFG_MIN_RAW)) begin
                r_min_raw <= i_cfg_data;
            end else if (i_cfg_idx == IDX_W'(CFG_MAX_RAW)) begin
                r_max_raw <= i_cfg_data;
            end
        end
    end

    assign w_den = {r_max_raw[RAW_W-1], r_max_raw} - {r_min_raw[RAW_W-1], r_min_raw};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_den.mag  <= DEN_W'(MAX_RAW_RST - MIN_RAW_RST);
            r_den.neg  <= 1'b0;
            r_den.zero <= 1'b0;
        end else begin
            r_den.mag  <= w_den[DEN_W-1] ? DEN_W'(-w_den) : DEN_W'(w_den);
            r_den.neg  <= w_den[DEN_W-1];
            r_den.zero <= (w_den == '0);
        end
    end

    dtrr_map u_map_one (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (i_valid),
        .i_raw_a (i_accel1_x),
        .i_raw_b (i_accel1_z),
        .i_min   (r_min_raw),
        .i_den   (r_den),
        .o_valid (w_vm1),
        .o_axis_a(w_m1x),
        .o_axis_b(w_m1z)
    );

    dtrr_map u_map_two (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (i_valid),
        .i_raw_a (i_accel2_y),
        .i_raw_b (i_accel2_z),
        .i_min   (r_min_raw),
        .i_den   (r_den),
        .o_valid (w_vm2),
        .o_axis_a(w_m2y),
        .o_axis_b(w_m2z)
    );

    dtrr_cordic u_cordic_one (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_vm1 & w_vm2),
        .i_a     (w_m1x),
        .i_b     (w_m1z),
        .o_valid (w_vc1),
        .o_acc   (w_acc1)
    );

    dtrr_cordic u_cordic_two (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_vm1 & w_vm2),
        .i_a     (w_m2y),
        .i_b     (w_m2z),
        .o_valid (w_vc2),
        .o_acc   (w_acc2)
    );

    dtrr_post u_post (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_adv            (w_adv),
        .i_valid          (w_vc1 & w_vc2),
        .i_acc_one        (w_acc1),
        .i_acc_two        (w_acc2),
        .o_valid          (o_valid),
        .o_tilt_one       (o_tilt_one),
        .o_offset_one     (o_offset_one),
        .o_tilt_two       (o_tilt_two),
        .o_offset_two     (o_offset_two),
        .o_stick_rotation (o_stick_rotation)
    );

endmodule

FILE: tb/sv/dual_tilt_relative_rotation_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dual_tilt_relative_rotation_unit_tb
// Self-checking bench: directed sample pairs, then random traffic over several
// calibrations, compared field by field to typed rows or a bit-exact predictor.
// ----------------------------------------------------------------------------
module dual_tilt_relative_rotation_unit_tb;
    import dtrr_pkg::*;

    localparam int  LIMIT_CYCLES = 600000;
    localparam int  DRAIN_CYCLES = 80;

    typedef enum int {PACE_FREE, PACE_SRC_IDLE, PACE_SNK_STALL, PACE_BOTH} t_pace;

    typedef struct packed {
        t_deg tilt_one;
        t_off offset_one;
        t_deg tilt_two;
        t_off offset_two;
        t_rot stick_rotation;
    } t_tilt_res;

    typedef struct {
        t_raw      a1x, a1z, a2y, a2z;
        bit        typed;
        t_tilt_res res;
    } t_row;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          o_ready;
    t_raw          i_accel1_x = '0, i_accel1_z = '0, i_accel2_y = '0, i_accel2_z = '0;
    logic          o_valid;
    logic          i_ready = 1'b0;
    t_deg          o_tilt_one, o_tilt_two;
    t_off          o_offset_one, o_offset_two;
    t_rot          o_stick_rotation;
    logic          i_cfg_we = 1'b0;
    logic [IDX_W-1:0] i_cfg_idx = '0;
    logic [RAW_W-1:0] i_cfg_data = '0;

    longint        cal_min = 265, cal_max = 402;
    t_tilt_res     pending_tilts[$];
    int            mismatches = 0;
    int            cycle_cnt = 0;
    t_pace         pace = PACE_FREE;
    bit            long_hold = 1'b0;

    dual_tilt_relative_rotation_unit dut (.*);

    always #6 i_clk = ~i_clk;

    // --- predictor ----------------------------------------------------------
    function automatic longint map_axis_deg(t_raw r);
        longint den;
        den = cal_max - cal_min;
        if (den == 0) return -90;
        return (longint'(r) - cal_min) * 180 / den - 90;
    endfunction

    function automatic longint atan_q24(longint yv, longint xv);
        longint acc, px, py, t, dx, dy;
        acc = 0;
        if (yv == 0) return (xv < 0) ? (longint'(180) <<< ACC_FRAC) : 0;
        if (xv == 0) return (yv > 0) ? (longint'(90) <<< ACC_FRAC)
                                     : -(longint'(90) <<< ACC_FRAC);
        px = xv <<< PRESCALE;
        py = yv <<< PRESCALE;
        if (px < 0) begin
            if (py >= 0) begin
                t = px; px = py; py = -t; acc = longint'(90) <<< ACC_FRAC;
            end else begin
                t = px; px = -py; py = t; acc = -(longint'(90) <<< ACC_FRAC);
            end
        end
        for (int i = 0; i < CORDIC_STEPS && py != 0; i++) begin
            dx = py >>> i;
            dy = px >>> i;
            if (py > 0) begin
                px += dx; py -= dy; acc += longint'(atan_entry(i));
            end else begin
                px -= dx; py += dy; acc -= longint'(atan_entry(i));
            end
        end
        return acc;
    endfunction

    function automatic longint tilt_qf(longint a, longint b);
        longint t;
        t = atan_q24(-a, -b) + (longint'(180) <<< ACC_FRAC);
        if (t < 0) t = 0;
        if (t > (longint'(360) <<< ACC_FRAC)) t = longint'(360) <<< ACC_FRAC;
        return t >>> (ACC_FRAC - ANGLE_FRAC_BITS);
    endfunction

    function automatic t_tilt_res predict_tilts(t_raw a1x, t_raw a1z, t_raw a2y, t_raw a2z);
        longint t1, t2, g1, g2, off1, off2, ma, mb, rot;
        t_tilt_res r;
        t1 = tilt_qf(map_axis_deg(a1x), map_axis_deg(a1z));
        t2 = tilt_qf(map_axis_deg(a2y), map_axis_deg(a2z));
        g1 = t1 >>> ANGLE_FRAC_BITS;
        g2 = t2 >>> ANGLE_FRAC_BITS;
        off1 = (g1 <= 180) ? g1 : g1 - 360;
        // second offset keeps the fraction before truncating toward zero
        off2 = (g2 <= 180) ? g2
                           : -(((longint'(360) <<< ANGLE_FRAC_BITS) - t2) >>> ANGLE_FRAC_BITS);
        ma = off1 < 0 ? -off1 : off1;
        mb = off2 < 0 ? -off2 : off2;
        rot = (off1 > 0 && off2 <= 0) ? mb + ma : mb - ma;
        r.tilt_one = t_deg'(g1);
        r.offset_one = t_off'(off1);
        r.tilt_two = t_deg'(g2);
        r.offset_two = t_off'(off2);
        r.stick_rotation = t_rot'(rot);
        return r;
    endfunction

    // --- checking -----------------------------------------------------------
    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_cnt);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_tilt_res w;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_tilts.size() == 0) begin
                report_mismatch("unexpected transaction", 1, 0);
            end else begin
                w = pending_tilts.pop_front();
                if (o_tilt_one !== w.tilt_one)
                    report_mismatch("tilt_one", o_tilt_one, w.tilt_one);
                if (o_offset_one !== w.offset_one)
                    report_mismatch("offset_one", $signed(o_offset_one), $signed(w.offset_one));
                if (o_tilt_two !== w.tilt_two)
                    report_mismatch("tilt_two", o_tilt_two, w.tilt_two);
                if (o_offset_two !== w.offset_two)
                    report_mismatch("offset_two", $signed(o_offset_two), $signed(w.offset_two));
                if (o_stick_rotation !== w.stick_rotation)
                    report_mismatch("stick_rotation", $signed(o_stick_rotation),
                                    $signed(w.stick_rotation));
            end
        end
    end

    // --- receiver pacing ----------------------------------------------------
    always @(posedge i_clk) begin
        int hold_cnt;
        if (long_hold) begin
            // hold off long enough to fill the pipeline and stall the input
            i_ready <= 1'b0;
            for (hold_cnt = 0; hold_cnt < 200; hold_cnt++) @(posedge i_clk);
            long_hold = 1'b0;
            i_ready <= 1'b1;
        end else begin
            case (pace)
                PACE_SNK_STALL: i_ready <= ($urandom_range(99) >= 81);
                PACE_BOTH:      i_ready <= ($urandom_range(99) >= 14);
                default:        i_ready <= 1'b1;
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("timeout at cycle %0d", cycle_cnt);
            $display("dual_tilt_relative_rotation_unit_tb: FAIL");
            $finish;
        end
    end

    // --- sender -------------------------------------------------------------
    task automatic write_reg(int idx, longint val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= IDX_W'(idx);
        i_cfg_data <= RAW_W'(val);
        if (idx == CFG_MIN_RAW) cal_min = longint'($signed(RAW_W'(val)));
        if (idx == CFG_MAX_RAW) cal_max = longint'($signed(RAW_W'(val)));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_tilts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_pair(t_raw a1x, t_raw a1z, t_raw a2y, t_raw a2z,
                             bit typed, t_tilt_res res);
        int pct;
        pct = (pace == PACE_SRC_IDLE) ? 81 : (pace == PACE_BOTH) ? 14 : 0;
        if ($urandom_range(99) < pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < pct) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_accel1_x <= a1x;
        i_accel1_z <= a1z;
        i_accel2_y <= a2y;
        i_accel2_z <= a2z;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_tilts.push_back(typed ? res : predict_tilts(a1x, a1z, a2y, a2z));
    endtask

    function automatic t_raw pick_raw();
        longint lo, hi, v;
        if ($urandom_range(2) == 0) return t_raw'($urandom());
        lo = (cal_min < cal_max) ? cal_min : cal_max;
        hi = (cal_min < cal_max) ? cal_max : cal_min;
        v = lo - 8 + longint'($urandom_range(int'(hi - lo) + 16));
        if (v < -32768) v = -32768;
        if (v > 32767) v = 32767;
        return t_raw'(v);
    endfunction

    t_row directed[] = '{
        '{16'sd334, 16'sd334, 16'sd334, 16'sd334, 1'b1, '{9'd180, 9'sd180, 9'd180, 9'sd180, 10'sd0}},
        '{16'sd334, 16'sd402, 16'sd334, 16'sd402, 1'b1, '{9'd360, 9'sd0, 9'd360, 9'sd0, 10'sd0}},
        '{16'sd402, 16'sd334, 16'sd265, 16'sd334, 1'b1, '{9'd90, 9'sd90, 9'd270, -9'sd90, 10'sd180}},
        '{16'sd265, 16'sd334, 16'sd402, 16'sd334, 1'b0, '0},
        '{16'sd334, 16'sd265, 16'sd334, 16'sd265, 1'b0, '0},
        '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 1'b0, '0},
        '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0, '0},
        '{-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768, 1'b0, '0},
        '{16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, 1'b0, '0},
        '{16'sd0, -16'sd1, 16'sd0, -16'sd1, 1'b0, '0},
        '{16'sd300, 16'sd380, 16'sd290, 16'sd390, 1'b0, '0},
        '{16'sd390, 16'sd280, 16'sd270, 16'sd280, 1'b0, '0},
        '{16'sd333, 16'sd335, 16'sd335, 16'sd333, 1'b0, '0},
        '{16'sd400, 16'sd400, 16'sd266, 16'sd266, 1'b0, '0}
    };

    initial begin
        longint cal_set[6][2] = '{'{265, 402}, '{-32768, 32767}, '{100, 100},
                                  '{32767, -32768}, '{0, 1}, '{-5, -300}};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k])
            send_pair(directed[k].a1x, directed[k].a1z, directed[k].a2y,
                      directed[k].a2z, directed[k].typed, directed[k].res);
        i_valid <= 1'b0;
        wait_drained();

        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) begin
                write_reg(CFG_MIN_RAW, cal_set[ph][0]);
                write_reg(CFG_MAX_RAW, cal_set[ph][1]);
                if (ph == 2) write_reg(2, 16'h5a5a);   // unmapped index, ignored
            end
            if (ph == 1) long_hold = 1'b1;
            for (int n = 0; n < 150; n++) begin
                if (n % 38 == 0) pace = t_pace'((n / 38 + ph) % 4);
                send_pair(pick_raw(), pick_raw(), pick_raw(), pick_raw(), 1'b0, '0);
            end
            i_valid <= 1'b0;
            // pause the source until every result is back
            wait_drained();
        end

        if (mismatches == 0)
            $display("dual_tilt_relative_rotation_unit_tb: PASS");
        else
            $display("dual_tilt_relative_rotation_unit_tb: FAIL");
        $finish;
    end

endmodule
